### hw/rtl/fas_pkg.sv
// ============================================================================
// fas_pkg: shared types and constants for the frame animation sequencer
// Command codes, register indexes, request/result records and reset values.
// ============================================================================
package fas_pkg;

  // Default cap on the number of frames
  localparam int unsigned MAX_FRAMES_DFLT = 64;

  // Widths fixed by the command and register formats
  localparam int unsigned FRAME_CNT_W = 7;
  localparam int unsigned FRAME_W     = 6;
  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned LOOPS_W     = 16;
  localparam int unsigned LOOPS_CNT_W = LOOPS_W + 1;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned REQ_W       = 32;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [PERIOD_W-1:0]    PERIOD_DFLT = 16'd100;
  localparam logic [LOOPS_CNT_W-1:0] LOOPS_INF   = '1;  // -1, loop forever

  // Command codes
  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_STOP    = 3'd1,
    OP_SET     = 3'd2,
    OP_PLAY    = 3'd3,
    OP_BIND    = 3'd4,
    OP_RESTART = 3'd5
  } op_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_FRAME     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_PERIOD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_LOOPS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTOPLAY       = 3'd4;

  typedef struct packed {
    logic [FRAME_CNT_W-1:0] frame_count;
    logic [FRAME_W-1:0]     idle_frame;
    logic [PERIOD_W-1:0]    default_period;
    logic [LOOPS_W-1:0]     default_loops;
    logic                   autoplay;
  } cfg_t;

  typedef struct packed {
    logic [2:0]          op;
    logic [TIME_W-1:0]   now_ms;
    logic [REQ_W-1:0]    frame_request;
    logic                period_given;
    logic [PERIOD_W-1:0] period_request;
    logic                loops_given;
    logic [LOOPS_W-1:0]  loops_request;
  } req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               playing;
    logic               changed;
  } res_t;

endpackage

### hw/rtl/frame_animation_sequencer_core.sv
// ============================================================================
// frame_animation_sequencer_core: frame sequencer for one animated image
// Top level: request register, command engine, result register, config regs.
// ============================================================================
// Each request is one command (tick, stop, set frame, play, bind, restart)
// and yields exactly one result: the frame shown, whether playback runs, and
// whether the display needs a refresh. A request passes through an input
// register, is decoded combinationally against the playback state, and
// lands in a result register, which raises out_valid; one request is
// accepted every cycle while the result side keeps up. Throughput is
// bounded only by out_ready; a held result stalls the input register,
// which in turn drops in_ready. Tick timing uses wrapping 32-bit
// millisecond subtraction; a stamped time of zero reads as "not started".
// Config registers are written by index with no wait and should only
// change while no request is in flight. MAX_FRAMES caps the usable
// frame count.
module frame_animation_sequencer_core #(
  parameter int unsigned MAX_FRAMES = fas_pkg::MAX_FRAMES_DFLT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        in_op,
  input  logic [fas_pkg::TIME_W-1:0]         in_now_ms,
  input  logic signed [fas_pkg::REQ_W-1:0]   in_frame_request,
  input  logic                              in_period_given,
  input  logic [fas_pkg::PERIOD_W-1:0]       in_period_request,
  input  logic                              in_loops_given,
  input  logic [fas_pkg::LOOPS_W-1:0]        in_loops_request,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fas_pkg::FRAME_W-1:0]        out_frame,
  output logic                              out_playing,
  output logic                              out_changed,
  // config write port
  input  logic                              cfg_we,
  input  logic [fas_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fas_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import fas_pkg::*;

  cfg_t cfg;
  req_t in_req, req;
  res_t res, out_res;
  logic req_valid;
  logic advance;

  assign in_req.op             = in_op;
  assign in_req.now_ms         = in_now_ms;
  assign in_req.frame_request  = in_frame_request;
  assign in_req.period_given   = in_period_given;
  assign in_req.period_request = in_period_request;
  assign in_req.loops_given    = in_loops_given;
  assign in_req.loops_request  = in_loops_request;

  // request moves on when the result slot is free or being emptied
  assign advance = req_valid && (!out_valid || out_ready);

  fas_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  fas_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .advance   (advance),
    .req_valid (req_valid),
    .req       (req)
  );

  fas_engine #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .req     (req),
    .cfg     (cfg),
    .res     (res)
  );

  fas_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_frame   = out_res.frame;
  assign out_playing = out_res.playing;
  assign out_changed = out_res.changed;

endmodule

### hw/rtl/fas_cfg_regs.sv
// ============================================================================
// fas_cfg_regs: configuration register file
// Five write-only registers, written by index with no wait state.
// ============================================================================
module fas_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [fas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fas_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output fas_pkg::cfg_t                 cfg
);
  import fas_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_COUNT:    cfg_nxt.frame_count    = cfg_wdata[FRAME_CNT_W-1:0];
        CFG_IDLE_FRAME:     cfg_nxt.idle_frame     = cfg_wdata[FRAME_W-1:0];
        CFG_DEFAULT_PERIOD: cfg_nxt.default_period = cfg_wdata[PERIOD_W-1:0];
        CFG_DEFAULT_LOOPS:  cfg_nxt.default_loops  = cfg_wdata[LOOPS_W-1:0];
        CFG_AUTOPLAY:       cfg_nxt.autoplay       = cfg_wdata[0];
        default:            cfg_nxt = cfg_r;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_count    <= '0;
      cfg_r.idle_frame     <= '0;
      cfg_r.default_period <= PERIOD_DFLT;
      cfg_r.default_loops  <= '0;
      cfg_r.autoplay       <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### hw/rtl/fas_in_stage.sv
// ============================================================================
// fas_in_stage: input request register
// Holds one request until the engine consumes it; refills in the same cycle.
// ============================================================================
module fas_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  fas_pkg::req_t in_req,
  input  logic          advance,
  output logic          req_valid,
  output fas_pkg::req_t req
);
  import fas_pkg::*;

  logic valid_r, valid_nxt;
  req_t req_r;
  logic take;

  assign in_ready = !valid_r || advance;
  assign take     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take)         valid_nxt = 1'b1;
    else if (advance) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req_r <= in_req;
    end
  end

  assign req_valid = valid_r;
  assign req       = req_r;

endmodule

### hw/rtl/fas_engine.sv
// ============================================================================
// fas_engine: sequencer state and command decode
// Applies one command per cycle, while advance is high, to the playback state and forms its result.
// ============================================================================
module fas_engine #(
  parameter int unsigned MAX_FRAMES = fas_pkg::MAX_FRAMES_DFLT
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          advance,
  input  fas_pkg::req_t req,
  input  fas_pkg::cfg_t cfg,
  output fas_pkg::res_t res
);
  import fas_pkg::*;

  // frame_count cannot exceed its own field, so the cap folds into 7 bits
  localparam int unsigned CNT_MAX = (1 << FRAME_CNT_W) - 1;
  localparam int unsigned CAP     = (MAX_FRAMES > CNT_MAX) ? CNT_MAX : MAX_FRAMES;
  localparam logic [FRAME_CNT_W-1:0] CAP_N = CAP[FRAME_CNT_W-1:0];

  logic                   playing_r, playing_nxt;
  logic [FRAME_CNT_W-1:0] cur_r, cur_nxt;
  logic [LOOPS_CNT_W-1:0] loops_r, loops_nxt;
  logic [TIME_W-1:0]      last_r, last_nxt;
  logic [PERIOD_W-1:0]    period_r, period_nxt;

  logic [FRAME_CNT_W-1:0] n;
  logic                   has_frames;
  logic [FRAME_CNT_W-1:0] last_idx;
  logic [FRAME_CNT_W-1:0] rest_cl;
  logic [FRAME_CNT_W-1:0] req_cl;
  logic [TIME_W-1:0]      elapsed;
  logic [PERIOD_W-1:0]    period_eff;
  logic [FRAME_CNT_W:0]   cur_inc;
  logic                   wrap;
  logic [PERIOD_W-1:0]    per_sel;
  logic [LOOPS_W-1:0]     loops_sel;
  logic [PERIOD_W-1:0]    play_period;
  logic [LOOPS_CNT_W-1:0] play_loops;
  logic [LOOPS_CNT_W-1:0] loops_dec;
  logic                   changed;

  always_comb begin
    n          = (cfg.frame_count > CAP_N) ? CAP_N : cfg.frame_count;
    has_frames = (n != '0);
    last_idx   = n - 1'b1;
    rest_cl    = ({1'b0, cfg.idle_frame} < n) ? {1'b0, cfg.idle_frame} : last_idx;

    // signed request clamped into [0, n-1]
    if (req.frame_request[REQ_W-1])
      req_cl = '0;
    else if ((req.frame_request[REQ_W-2:FRAME_CNT_W] != '0) ||
             (req.frame_request[FRAME_CNT_W-1:0] >= n))
      req_cl = last_idx;
    else
      req_cl = req.frame_request[FRAME_CNT_W-1:0];

    elapsed    = req.now_ms - last_r;
    period_eff = (period_r == '0) ? PERIOD_DFLT : period_r;
    cur_inc    = {1'b0, cur_r} + 1'b1;
    wrap       = (cur_inc >= {1'b0, n});
    loops_dec  = loops_r - 1'b1;

    per_sel     = req.period_given ? req.period_request : cfg.default_period;
    loops_sel   = req.loops_given ? req.loops_request : cfg.default_loops;
    play_period = (per_sel == '0) ? PERIOD_DFLT : per_sel;
    play_loops  = (loops_sel == '0) ? LOOPS_INF : {1'b0, loops_sel};
  end

  always_comb begin
    playing_nxt = playing_r;
    cur_nxt     = cur_r;
    loops_nxt   = loops_r;
    last_nxt    = last_r;
    period_nxt  = period_r;
    changed     = 1'b0;

    case (req.op)
      OP_TICK: begin
        if (playing_r) begin
          if (!has_frames) begin
            playing_nxt = 1'b0;
          end else if (last_r == '0) begin
            last_nxt = req.now_ms;       // first tick only stamps the time
          end else if (elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, period_eff}) begin
            last_nxt = req.now_ms;
            changed  = 1'b1;
            cur_nxt  = cur_inc[FRAME_CNT_W-1:0];
            if (wrap) begin
              cur_nxt = '0;
              // positive count: finite loops, decrement and stop at zero
              if (!loops_r[LOOPS_CNT_W-1] && (loops_r != '0)) begin
                loops_nxt = loops_dec;
                if (loops_dec == '0) begin
                  playing_nxt = 1'b0;
                  cur_nxt     = rest_cl;
                end
              end
            end
          end
        end
      end
      OP_STOP: begin
        playing_nxt = 1'b0;
        cur_nxt     = has_frames ? rest_cl : '0;
        changed     = 1'b1;
      end
      OP_SET: begin
        cur_nxt     = has_frames ? req_cl : '0;
        playing_nxt = 1'b0;
        changed     = 1'b1;
      end
      OP_PLAY: begin
        changed = 1'b1;
        if (has_frames) begin
          period_nxt  = play_period;
          loops_nxt   = play_loops;
          playing_nxt = 1'b1;
          last_nxt    = '0;
          cur_nxt     = '0;
        end
      end
      OP_BIND: begin
        if (!playing_r && has_frames && (req_cl != cur_r)) begin
          cur_nxt = req_cl;
          changed = 1'b1;
        end
      end
      OP_RESTART: begin
        changed = 1'b1;
        last_nxt = '0;
        if (cfg.autoplay && has_frames) begin
          playing_nxt = 1'b1;
          cur_nxt     = '0;
          period_nxt  = (cfg.default_period == '0) ? PERIOD_DFLT : cfg.default_period;
          loops_nxt   = (cfg.default_loops == '0) ? LOOPS_INF
                                                  : {1'b0, cfg.default_loops};
        end else begin
          playing_nxt = 1'b0;
          loops_nxt   = LOOPS_INF;
          period_nxt  = PERIOD_DFLT;
          cur_nxt     = has_frames ? rest_cl : {1'b0, cfg.idle_frame};
        end
      end
      default: begin
        changed = 1'b0;  // unused codes leave the state alone
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      playing_r <= 1'b0;
      cur_r     <= '0;
      loops_r   <= LOOPS_INF;
      last_r    <= '0;
      period_r  <= PERIOD_DFLT;
    end else if (advance) begin
      playing_r <= playing_nxt;
      cur_r     <= cur_nxt;
      loops_r   <= loops_nxt;
      last_r    <= last_nxt;
      period_r  <= period_nxt;
    end
  end

  assign res.frame   = cur_nxt[FRAME_W-1:0];
  assign res.playing = playing_nxt;
  assign res.changed = changed;

endmodule

### hw/rtl/fas_out_stage.sv
// ============================================================================
// fas_out_stage: result register
// Holds one result until the consumer takes it.
// ============================================================================
module fas_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  fas_pkg::res_t res,
  output logic          out_valid,
  input  logic          out_ready,
  output fas_pkg::res_t out_res
);
  import fas_pkg::*;

  logic valid_r, valid_nxt;
  res_t res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load)           valid_nxt = 1'b1;
    else if (out_ready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

### test/tb_top.sv
// ============================================================================
// tb_top: self-checking bench for frame_animation_sequencer_core
// Drives tick, stop, set, play, bind, restart and spare-code requests through the
// valid/ready request channel, predicts each result in lockstep with a
// playback model kept in the bench, and checks every returned result in order.
// ============================================================================
module tb_top;
  import fas_pkg::*;

  // Cycles with no handshake on either channel before the run is called hung.
  // The longest legal quiet stretch is the receiver hold-off below.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_REQUESTS = 100;
  localparam int NUM_PHASES     = 8;

  // Op codes the block does not define; they must pass through untouched.
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  // Receiver behaviors
  localparam int RX_ALWAYS  = 0;
  localparam int RX_RANDOM  = 1;
  localparam int RX_PATTERN = 2;

  logic                 clk               = 1'b0;
  logic                 rst_n             = 1'b0;
  logic                 in_valid          = 1'b0;
  logic                 in_ready;
  logic [2:0]           in_op             = '0;
  logic [TIME_W-1:0]    in_now_ms         = '0;
  logic [REQ_W-1:0]     in_frame_request  = '0;
  logic                 in_period_given   = 1'b0;
  logic [PERIOD_W-1:0]  in_period_request = '0;
  logic                 in_loops_given    = 1'b0;
  logic [LOOPS_W-1:0]   in_loops_request  = '0;
  logic                 out_valid;
  logic                 out_ready         = 1'b0;
  logic [FRAME_W-1:0]   out_frame;
  logic                 out_playing;
  logic                 out_changed;
  logic                 cfg_we            = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index         = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata        = '0;

  frame_animation_sequencer_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_now_ms         (in_now_ms),
    .in_frame_request  (in_frame_request),
    .in_period_given   (in_period_given),
    .in_period_request (in_period_request),
    .in_loops_given    (in_loops_given),
    .in_loops_request  (in_loops_request),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame         (out_frame),
    .out_playing       (out_playing),
    .out_changed       (out_changed),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Playback model: bench copy of the registers and of the sequencer state.
  // --------------------------------------------------------------------------
  int           cfg_frames   = 0;
  int           cfg_rest     = 0;
  int           cfg_period   = 100;
  int           cfg_loops    = 0;
  bit           cfg_autoplay = 1'b0;

  bit           seq_playing  = 1'b0;
  int           seq_frame    = 0;
  int           seq_loops    = -1;     // -1: loop forever
  logic [31:0]  seq_stamp    = '0;     // 0: not started yet
  int           seq_period   = 100;

  res_t         pending_frames[$];     // predicted results, oldest first

  // Bench bookkeeping
  int           errors         = 0;
  int           requests_sent  = 0;
  int           results_seen   = 0;
  int           settings_run   = 0;
  int           burst_left     = 0;
  bit           gaps_on        = 1'b0;
  int           rx_mode        = RX_ALWAYS;
  int           rx_count       = 0;
  int           hold_left      = 0;
  int           quiet_cycles   = 0;
  logic [31:0]  sim_ms         = 32'h0000_1000;

  // Rest frame as shown with n frames present
  function automatic int rest_shown(input int n);
    return (cfg_rest < n) ? cfg_rest : n - 1;
  endfunction

  function automatic void begin_playback(input int per, input int loops);
    seq_period  = (per == 0) ? 100 : per;
    seq_loops   = (loops == 0) ? -1 : loops;
    seq_playing = 1'b1;
    seq_stamp   = '0;
    seq_frame   = 0;
  endfunction

  // Applies one request to the model state and returns the result it yields.
  function automatic res_t sequence_step(input logic [2:0] op, input logic [31:0] now,
      input logic signed [31:0] req, input logic pg, input logic [15:0] preq,
      input logic lg, input logic [15:0] lreq);
    int          n;
    int          r;
    int          nf;
    int          per;
    logic [31:0] elapsed;
    logic        changed;
    res_t        res;
    n       = (cfg_frames > int'(MAX_FRAMES_DFLT)) ? int'(MAX_FRAMES_DFLT) : cfg_frames;
    r       = req;
    changed = 1'b0;
    case (op)
      OP_TICK: begin
        if (seq_playing) begin
          if (n == 0) begin
            seq_playing = 1'b0;
          end else if (seq_stamp == '0) begin
            seq_stamp = now;
          end else begin
            per     = (seq_period == 0) ? 100 : seq_period;
            elapsed = now - seq_stamp;      // wraps like the 32-bit timer
            if (elapsed >= 32'(per)) begin
              seq_stamp = now;
              nf = seq_frame + 1;
              if (nf >= n) begin
                nf = 0;
                if (seq_loops > 0) begin
                  seq_loops--;
                  if (seq_loops == 0) begin
                    seq_playing = 1'b0;
                    nf = rest_shown(n);
                  end
                end
              end
              seq_frame = nf;
              changed   = 1'b1;
            end
          end
        end
      end
      OP_STOP: begin
        seq_playing = 1'b0;
        seq_frame   = (n != 0) ? rest_shown(n) : 0;
        changed     = 1'b1;
      end
      OP_SET: begin
        if (n == 0 || r < 0) seq_frame = 0;
        else if (r >= n) seq_frame = n - 1;
        else seq_frame = r;
        seq_playing = 1'b0;
        changed     = 1'b1;
      end
      OP_PLAY: begin
        changed = 1'b1;
        if (n != 0) begin
          begin_playback(pg ? int'(preq) : cfg_period, lg ? int'(lreq) : cfg_loops);
        end
      end
      OP_BIND: begin
        if (!seq_playing && n > 0) begin
          if (r < 0) nf = 0;
          else if (r >= n) nf = n - 1;
          else nf = r;
          if (nf != seq_frame) begin
            seq_frame = nf;
            changed   = 1'b1;
          end
        end
      end
      OP_RESTART: begin
        seq_playing = 1'b0;
        seq_loops   = -1;
        seq_period  = 100;
        seq_stamp   = '0;
        seq_frame   = (n != 0) ? rest_shown(n) : cfg_rest;
        if (cfg_autoplay && n > 0) begin_playback(cfg_period, cfg_loops);
        changed = 1'b1;
      end
      default: ;  // spare codes leave everything alone
    endcase
    res.frame   = 6'(seq_frame);
    res.playing = seq_playing;
    res.changed = changed;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: receiver stalls, result check, watchdog
  // --------------------------------------------------------------------------

  // A hold-off requested by a test runs first; otherwise the current mode
  // decides out_ready for the next cycle.
  always @(negedge clk) begin
    rx_count++;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
        default:   out_ready <= ((rx_count % 7) < 4);
      endcase
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch at result %0d: %s got %0d expected %0d",
             results_seen, what, got, want);
  endtask

  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_frames.size() == 0) begin
        report_mismatch("result with no request pending", out_frame, -1);
      end else begin
        want = pending_frames.pop_front();
        if (out_frame !== want.frame)
          report_mismatch("frame", out_frame, want.frame);
        if (out_playing !== want.playing)
          report_mismatch("playing", out_playing, want.playing);
        if (out_changed !== want.changed)
          report_mismatch("changed", out_changed, want.changed);
      end
      results_seen++;
    end
  end

  // Hang detector: any handshake clears it
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Presents one request at a falling edge and holds it until accepted.
  // Gaps fall between bursts; in this task valid is only lowered at the start of a gap.
  task automatic send_cmd(input logic [2:0] op, input logic [31:0] now,
      input logic [31:0] req, input logic pg, input logic [15:0] preq,
      input logic lg, input logic [15:0] lreq);
    int gap;
    gap = 0;
    @(negedge clk);
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap        = $urandom_range(1, 8);
      end
      burst_left--;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_op             <= op;
    in_now_ms         <= now;
    in_frame_request  <= req;
    in_period_given   <= pg;
    in_period_request <= preq;
    in_loops_given    <= lg;
    in_loops_request  <= lreq;
    do @(posedge clk); while (!in_ready);
    pending_frames.push_back(sequence_step(op, now, req, pg, preq, lg, lreq));
    requests_sent++;
  endtask

  task automatic tick_at(input logic [31:0] now);
    send_cmd(OP_TICK, now, '0, 1'b0, '0, 1'b0, '0);
  endtask

  task automatic frame_cmd(input logic [2:0] op, input logic [31:0] req);
    send_cmd(op, '0, req, 1'b0, '0, 1'b0, '0);
  endtask

  task automatic play_cmd(input logic pg, input logic [15:0] preq,
      input logic lg, input logic [15:0] lreq);
    send_cmd(OP_PLAY, '0, '0, pg, preq, lg, lreq);
  endtask

  // Register write at a falling edge, taken at the next rising edge.
  // The model copy is masked to the register width like the hardware.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[15:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_FRAME_COUNT:    cfg_frames   = value & 32'h7F;
      CFG_IDLE_FRAME:     cfg_rest     = value & 32'h3F;
      CFG_DEFAULT_PERIOD: cfg_period   = value & 32'hFFFF;
      CFG_DEFAULT_LOOPS:  cfg_loops    = value & 32'hFFFF;
      CFG_AUTOPLAY:       cfg_autoplay = value[0];
      default: ;
    endcase
  endtask

  task automatic write_all_regs(input int frames, input int rest, input int per,
      input int loops, input int auto_on);
    write_reg(CFG_FRAME_COUNT, frames);
    write_reg(CFG_IDLE_FRAME, rest);
    write_reg(CFG_DEFAULT_PERIOD, per);
    write_reg(CFG_DEFAULT_LOOPS, loops);
    write_reg(CFG_AUTOPLAY, auto_on);
    settings_run++;
  endtask

  // Stop offering requests and wait until every predicted result is back,
  // then let the input and result registers drain. Ends on a rising edge.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random request. Ticks mostly walk a running clock forward by steps near
  // the active period so frames really advance; a few carry arbitrary times.
  task automatic send_random_cmd();
    int          pick;
    int          span;
    logic [2:0]  op;
    logic [31:0] now;
    logic [31:0] req;
    logic        pg;
    logic        lg;
    logic [15:0] preq;
    logic [15:0] lreq;
    pick = $urandom_range(0, 99);
    if (pick < 58)      op = OP_TICK;
    else if (pick < 68) op = OP_PLAY;
    else if (pick < 74) op = OP_STOP;
    else if (pick < 80) op = OP_SET;
    else if (pick < 88) op = OP_BIND;
    else if (pick < 94) op = OP_RESTART;
    else if (pick < 97) op = OP_SPARE6;
    else                op = OP_SPARE7;

    span   = seq_period + seq_period / 2 + 1;
    sim_ms = sim_ms + 32'($urandom_range(0, span));
    now    = ($urandom_range(0, 19) == 0) ? 32'($urandom()) : sim_ms;

    // Frame requests mostly near the valid range, a few negative
    req = 32'($urandom_range(0, 70)) - 32'd3;
    if ($urandom_range(0, 9) == 0) req = $urandom();

    pg   = $urandom_range(0, 1);
    preq = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                       : 16'($urandom_range(0, 40));
    lg   = $urandom_range(0, 1);
    lreq = ($urandom_range(0, 6) == 0) ? 16'($urandom_range(0, 65535))
                                       : 16'($urandom_range(0, 3));
    send_cmd(op, now, req, pg, preq, lg, lreq);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // No frames loaded: every command must behave without an asset.
  task automatic test_no_asset();
    rx_mode = RX_ALWAYS;
    gaps_on = 1'b0;
    write_reg(CFG_IDLE_FRAME, 9);
    settings_run++;
    play_cmd(1'b0, '0, 1'b0, '0);     // ignored but flags a refresh
    tick_at(32'd500);
    frame_cmd(OP_STOP, '0);
    frame_cmd(OP_SET, 32'd5);         // shows 0 without frames
    frame_cmd(OP_BIND, 32'd3);        // no effect without frames
    frame_cmd(OP_RESTART, '0);        // shows rest frame unclamped
    frame_cmd(OP_SPARE6, 32'd1);
    frame_cmd(OP_SPARE7, 32'd1);
    wait_idle();
  endtask

  // Hand-picked playback sequence with four frames and a single loop.
  task automatic test_directed_playback();
    rx_mode = RX_RANDOM;
    gaps_on = 1'b1;
    write_all_regs(4, 9, 10, 1, 0);   // rest frame clamps to 3
    play_cmd(1'b0, '0, 1'b0, '0);     // defaults: 10 ms, one loop
    tick_at(32'h0000_0000);           // stamp of zero still reads unstarted
    tick_at(32'hFFFF_FFF8);           // first real stamp
    tick_at(32'h0000_0001);           // 9 ms across the wrap: too early
    tick_at(32'h0000_0002);           // 10 ms: frame 1
    tick_at(32'd12);
    tick_at(32'd22);
    tick_at(32'd32);                  // last loop ends: stop at rest frame
    tick_at(32'd42);                  // stopped, nothing happens
    frame_cmd(OP_BIND, 32'd3);        // same frame, no refresh
    frame_cmd(OP_BIND, 32'hFFFF_FFFB);
    frame_cmd(OP_BIND, 32'h7FFF_FFFF);
    frame_cmd(OP_SET, 32'h8000_0000);
    play_cmd(1'b1, '0, 1'b1, '0);     // zero period acts as 100, endless
    frame_cmd(OP_BIND, 32'd2);        // ignored while playing
    tick_at(32'hFFFF_FFFF);
    tick_at(32'd99);                  // exactly 100 ms later
    frame_cmd(OP_STOP, '0);
    play_cmd(1'b1, 16'hFFFF, 1'b1, 16'hFFFF);
    wait_idle();
    write_reg(CFG_AUTOPLAY, 1);
    frame_cmd(OP_RESTART, '0);        // autoplay with the defaults
    tick_at(32'd1000);
    wait_idle();
    write_reg(CFG_FRAME_COUNT, 0);    // asset gone while playing
    tick_at(32'd2000);
    wait_idle();
  endtask

  // Random requests over a spread of register settings, extremes included:
  // one frame, the frame cap, a count above the cap, zero default period,
  // the longest period and loop count, and a rest frame beyond the count.
  task automatic test_random_phases();
    int ph_frames[NUM_PHASES] = '{4, 1, 64, 127, 0, 7, 100, 3};
    int ph_rest[NUM_PHASES]   = '{2, 0, 63, 63, 5, 40, 17, 1};
    int ph_period[NUM_PHASES] = '{10, 1, 65535, 0, 20, 3, 5, 2};
    int ph_loops[NUM_PHASES]  = '{0, 1, 65535, 2, 1, 3, 0, 1};
    int ph_auto[NUM_PHASES]   = '{0, 1, 1, 0, 1, 1, 1, 0};
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      rx_mode = p % 3;
      gaps_on = ((p % 4) != 1);
      if (p == 5) sim_ms = 32'hFFFF_F000;   // run the timer across its wrap
      write_all_regs(ph_frames[p], ph_rest[p], ph_period[p], ph_loops[p], ph_auto[p]);
      for (int i = 0; i < PHASE_REQUESTS; i++) send_random_cmd();
    end
  endtask

  // Receiver holds off long enough for the pipeline to fill and drop
  // in_ready while requests keep coming; then the sender drains fully.
  task automatic test_backpressure();
    wait_idle();
    rx_mode = RX_ALWAYS;
    gaps_on = 1'b0;
    write_all_regs(5, 2, 4, 2, 1);
    send_random_cmd();
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < 40; i++) send_random_cmd();
    wait_idle();
    rx_mode = RX_PATTERN;
    gaps_on = 1'b1;
    for (int i = 0; i < 20; i++) send_random_cmd();
  endtask

  task automatic finish_run();
    wait_idle();
    $display("%0d requests sent over %0d register settings, %0d results checked",
             requests_sent, settings_run, results_seen);
    $display("exercised all commands, finite and endless loops, timer wrap and stalls");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_no_asset();
    test_directed_playback();
    test_random_phases();
    test_backpressure();
    finish_run();
  end

endmodule
